### hdl/csws_pkg.sv
// Package for the comment strip and whitespace squeeze block.
// Holds the transfer payload types, character constants and scanner state codes.
// Used by comment_strip_whitespace_squeeze_core and its checker.
package csws_pkg;

  // character codes the scanner looks for
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0A;

  // input item kinds
  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // input payload
  typedef struct packed {
    logic       kind;
    logic [7:0] in_byte;
  } in_item_t;

  // result payload
  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_status;
    logic       is_error;
    logic       last;
  } out_item_t;

  // scanner states, one-hot
  typedef enum logic [14:0] {
    S_START  = 15'b000000000000001, // before any text
    S_SL0    = 15'b000000000000010, // slash at start
    S_CODE   = 15'b000000000000100, // in code
    S_LC0    = 15'b000000000001000, // line comment at start
    S_BC0    = 15'b000000000010000, // block comment at start
    S_BC0S   = 15'b000000000100000, // block comment at start, star seen
    S_SLW    = 15'b000000001000000, // slash after whitespace
    S_LCW    = 15'b000000010000000, // line comment after whitespace
    S_BCW    = 15'b000000100000000, // block comment after whitespace
    S_BCWS   = 15'b000001000000000, // block comment after whitespace, star seen
    S_SLC    = 15'b000010000000000, // slash after code
    S_LCC    = 15'b000100000000000, // line comment after code
    S_BCC    = 15'b001000000000000, // block comment after code
    S_BCCS   = 15'b010000000000000, // block comment after code, star seen
    S_WSC    = 15'b100000000000000  // whitespace following code
  } scan_state_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_NL);
  endfunction

endpackage

### hdl/comment_strip_whitespace_squeeze_core.sv
// Top level of the comment strip and whitespace squeeze block.
// Depends on csws_pkg for payload types, character constants and state codes.
//
// Source text enters one byte per transfer; line and block comments and leading
// whitespace are dropped, whitespace runs after code shrink to their first byte,
// and an end-of-input item yields one status result before the scanner restarts.
// An accepted item waits in the input register and is scanned from there; its
// results (none, one or two) land in a two-entry result buffer when the buffer is
// empty or its only result leaves, so an output stall holds the item back. Items
// with at most one result flow at one byte per cycle while the output does not
// stall; an item with two results holds up the next one, as the single result port
// drains the buffer one result per cycle.
module comment_strip_whitespace_squeeze_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  csws_pkg::in_item_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output csws_pkg::out_item_t out_data
);

  // input register
  logic                 a_valid;
  csws_pkg::in_item_t   a_item;
  // scanner state
  csws_pkg::scan_state_t scan_state, scan_state_next;
  logic                 error_seen, error_seen_next;
  // result buffer
  logic [1:0]           pend_cnt;
  csws_pkg::out_item_t  slot0, slot1;

  // scan outputs
  logic [1:0]           res_n;
  csws_pkg::out_item_t  res0, res1;
  logic [7:0]           b0, b1;
  logic [7:0]           c;

  logic out_fire, a_advance, in_fire;

  assign out_fire  = out_valid && !out_stall;
  assign a_advance = a_valid && ((pend_cnt == 2'd0) || ((pend_cnt == 2'd1) && out_fire));
  assign in_stall  = a_valid && !a_advance;
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = (pend_cnt != 2'd0);
  assign out_data  = slot0;
  assign c         = a_item.in_byte;

  // scanner next state and emitted bytes
  always_comb begin
    scan_state_next = scan_state;
    error_seen_next = error_seen;
    res_n = 2'd0;
    b0 = c;
    b1 = c;
    if (a_item.kind == csws_pkg::KIND_END) begin
      scan_state_next = csws_pkg::S_START;
      error_seen_next = 1'b0;
      res_n = 2'd1;
    end else if (!error_seen) begin
      unique case (scan_state)
        csws_pkg::S_START: begin
          if (csws_pkg::is_ws(c)) begin
          end else if (c == csws_pkg::CH_SLASH) begin
            scan_state_next = csws_pkg::S_SL0;
          end else begin
            res_n = 2'd1;
            scan_state_next = csws_pkg::S_CODE;
          end
        end
        csws_pkg::S_SL0: begin
          if (c == csws_pkg::CH_SLASH) scan_state_next = csws_pkg::S_LC0;
          else if (c == csws_pkg::CH_STAR) scan_state_next = csws_pkg::S_BC0;
          else error_seen_next = 1'b1;
        end
        csws_pkg::S_CODE: begin
          if (csws_pkg::is_ws(c)) begin
            res_n = 2'd1;
            scan_state_next = csws_pkg::S_WSC;
          end else if (c == csws_pkg::CH_SLASH) begin
            scan_state_next = csws_pkg::S_SLC;
          end else begin
            res_n = 2'd1;
          end
        end
        csws_pkg::S_LC0: begin
          if (c == csws_pkg::CH_NL) scan_state_next = csws_pkg::S_START;
        end
        csws_pkg::S_BC0: begin
          if (c == csws_pkg::CH_STAR) scan_state_next = csws_pkg::S_BC0S;
        end
        csws_pkg::S_BC0S: begin
          if (c == csws_pkg::CH_SLASH) scan_state_next = csws_pkg::S_START;
          else if (c != csws_pkg::CH_STAR) scan_state_next = csws_pkg::S_BC0;
        end
        csws_pkg::S_SLW: begin
          if (c == csws_pkg::CH_STAR) begin
            scan_state_next = csws_pkg::S_BCW;
          end else if (c == csws_pkg::CH_SLASH) begin
            scan_state_next = csws_pkg::S_LCW;
          end else if (csws_pkg::is_ws(c)) begin
            // whitespace after the slash always comes out as a newline
            res_n = 2'd2;
            b0 = csws_pkg::CH_SLASH;
            b1 = csws_pkg::CH_NL;
            scan_state_next = csws_pkg::S_WSC;
          end else begin
            res_n = 2'd2;
            b0 = csws_pkg::CH_SLASH;
            scan_state_next = csws_pkg::S_CODE;
          end
        end
        csws_pkg::S_LCW: begin
          if (c == csws_pkg::CH_NL) scan_state_next = csws_pkg::S_WSC;
        end
        csws_pkg::S_BCW: begin
          if (c == csws_pkg::CH_STAR) scan_state_next = csws_pkg::S_BCWS;
        end
        csws_pkg::S_BCWS: begin
          if (c == csws_pkg::CH_SLASH) scan_state_next = csws_pkg::S_WSC;
          else if (c != csws_pkg::CH_STAR) scan_state_next = csws_pkg::S_BCW;
        end
        csws_pkg::S_SLC: begin
          if (csws_pkg::is_ws(c)) begin
            res_n = 2'd2;
            b0 = csws_pkg::CH_SLASH;
            scan_state_next = csws_pkg::S_WSC;
          end else if (c == csws_pkg::CH_SLASH) begin
            scan_state_next = csws_pkg::S_LCC;
          end else if (c == csws_pkg::CH_STAR) begin
            scan_state_next = csws_pkg::S_BCC;
          end else begin
            res_n = 2'd2;
            b0 = csws_pkg::CH_SLASH;
            scan_state_next = csws_pkg::S_CODE;
          end
        end
        csws_pkg::S_LCC: begin
          if (c == csws_pkg::CH_NL) begin
            res_n = 2'd1;
            scan_state_next = csws_pkg::S_WSC;
          end
        end
        csws_pkg::S_BCC: begin
          if (c == csws_pkg::CH_STAR) scan_state_next = csws_pkg::S_BCCS;
        end
        csws_pkg::S_BCCS: begin
          if (c == csws_pkg::CH_SLASH) scan_state_next = csws_pkg::S_CODE;
          else if (c != csws_pkg::CH_STAR) scan_state_next = csws_pkg::S_BCC;
        end
        csws_pkg::S_WSC: begin
          if (csws_pkg::is_ws(c)) begin
          end else if (c == csws_pkg::CH_SLASH) begin
            scan_state_next = csws_pkg::S_SLW;
          end else begin
            res_n = 2'd1;
            scan_state_next = csws_pkg::S_CODE;
          end
        end
        default: begin
          // illegal state code counts as a syntax error
          error_seen_next = 1'b1;
        end
      endcase
    end
  end

  // result words
  always_comb begin
    if (a_item.kind == csws_pkg::KIND_END) begin
      res0.out_byte  = 8'd0;
      res0.is_status = 1'b1;
      res0.is_error  = error_seen ||
                       (scan_state == csws_pkg::S_BC0) || (scan_state == csws_pkg::S_BC0S) ||
                       (scan_state == csws_pkg::S_BCW) || (scan_state == csws_pkg::S_BCWS) ||
                       (scan_state == csws_pkg::S_BCC) || (scan_state == csws_pkg::S_BCCS);
      res0.last      = 1'b1;
    end else begin
      res0.out_byte  = b0;
      res0.is_status = 1'b0;
      res0.is_error  = 1'b0;
      res0.last      = (res_n == 2'd1);
    end
    res1.out_byte  = b1;
    res1.is_status = 1'b0;
    res1.is_error  = 1'b0;
    res1.last      = 1'b1;
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_fire) begin
      a_valid <= 1'b1;
    end else if (a_advance) begin
      a_valid <= 1'b0;
    end
    if (in_fire) begin
      a_item <= in_data;
    end
  end

  // scanner state update
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state <= csws_pkg::S_START;
      error_seen <= 1'b0;
    end else if (a_advance) begin
      scan_state <= scan_state_next;
      error_seen <= error_seen_next;
    end
  end

  // result buffer, drained one transfer per cycle while the output is not stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_cnt <= 2'd0;
    end else if (a_advance) begin
      pend_cnt <= res_n;
    end else if (out_fire) begin
      pend_cnt <= pend_cnt - 2'd1;
    end
    if (a_advance) begin
      slot0 <= res0;
      slot1 <= res1;
    end else if (out_fire) begin
      slot0 <= slot1;
    end
  end

endmodule

### hdl/csws_checker.sv
// Port checker for comment_strip_whitespace_squeeze_core, with its bind.
// Depends on csws_pkg for the payload types.
module csws_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input csws_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input csws_pkg::out_item_t out_data
);

  // no result offered straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered right after reset");

  // a stalled input transfer keeps its payload
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input changed");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // a status result closes its item and carries no byte
  a_status_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.is_status |-> out_data.last && (out_data.out_byte == 8'd0))
    else $error("malformed status result");

  // error flag only on status results
  a_error_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.is_status |-> !out_data.is_error)
    else $error("error flag on byte result");

endmodule

bind comment_strip_whitespace_squeeze_core csws_checker u_csws_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
